/* sv/rsc_pkg.sv */
// rsc_pkg: shared types and constants of the RPN stack calculator.
// Holds the token and result formats, status codes and back-end states.
// No dependencies.
`default_nettype none

package rsc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned TOK_Q_DEPTH     = 2;
  localparam int unsigned RES_Q_DEPTH     = 2;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_ADD,
    TK_SUB,
    TK_MUL,
    TK_DIV,
    TK_EQ,
    TK_NL,
    TK_BAD
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } tok_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_EXTRA     = 3'd3,
    ST_BAD_CHAR  = 3'd4,
    ST_DIV_ZERO  = 3'd5
  } status_e;

  typedef struct packed {
    logic signed [7:0] value;
    status_e           status;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DIV
  } back_state_e;

endpackage

`default_nettype wire

/* sv/rsc_fifo.sv */
// rsc_fifo: small first-word-fall-through queue of packed words.
// Used between front and back end and for results. No dependencies.
`default_nettype none

module rsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/rsc_front.sv */
// rsc_front: accepts characters and turns them into tokens for the back end.
// Depends on rsc_pkg for the character constants and token format.
`default_nettype none

module rsc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    ch_i,
  output logic          full_o,
  input  logic          tok_full_i,
  output logic          tok_push_o,
  output rsc_pkg::tok_t tok_o
);

  import rsc_pkg::*;

  logic       is_space;
  logic       seen_q;

  assign full_o     = tok_full_i;
  assign is_space   = (ch_i == CH_SPACE);
  // drop spaces here: they never change back-end state
  assign tok_push_o = push_i && !tok_full_i && !is_space;

  always_comb begin
    // '0' has a zero low nibble, so the digit value is the low nibble
    tok_o.digit = ch_i[3:0];
    priority if (ch_i >= CH_0 && ch_i <= CH_9) begin
      tok_o.kind = TK_DIGIT;
    end else if (ch_i == CH_PLUS) begin
      tok_o.kind = TK_ADD;
    end else if (ch_i == CH_MINUS) begin
      tok_o.kind = TK_SUB;
    end else if (ch_i == CH_STAR) begin
      tok_o.kind = TK_MUL;
    end else if (ch_i == CH_SLASH) begin
      tok_o.kind = TK_DIV;
    end else if (ch_i == CH_EQ) begin
      tok_o.kind = TK_EQ;
    end else if (ch_i == CH_NL) begin
      tok_o.kind = TK_NL;
    end else begin
      tok_o.kind = TK_BAD;
    end
  end

  // mark that at least one character has been taken since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push_i && !tok_full_i) begin
      seen_q <= 1'b1;
    end
  end

  a_space_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && is_space) |-> !tok_push_o)
    else $error("space forwarded as token");

  a_seen_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(seen_q) |-> seen_q)
    else $error("seen flag cleared outside reset");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_push_o |-> !tok_full_i)
    else $error("token pushed into full queue");

endmodule

`default_nettype wire

/* sv/rsc_div.sv */
// rsc_div: iterative signed 8-bit divider, truncating toward zero.
// One quotient bit per cycle over the magnitudes. No dependencies.
`default_nettype none

module rsc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic signed [7:0] dividend_i,
  input  logic signed [7:0] divisor_i,
  output logic              done_o,
  output logic [7:0]        quotient_o
);

  logic [7:0] a_mag, b_mag;
  logic       busy_q;
  logic [2:0] step_q;
  logic [7:0] rem_q, rem_d;
  logic [8:0] shifted;
  logic [7:0] quo_q, quo_d, den_q;
  logic       neg_q, done_q, ge;

  assign a_mag = dividend_i[7] ? (~dividend_i + 8'd1) : dividend_i;
  assign b_mag = divisor_i[7]  ? (~divisor_i  + 8'd1) : divisor_i;

  // the remainder stays below the divisor, so eight bits hold it
  assign shifted = {rem_q, quo_q[7]};
  assign ge      = (shifted >= {1'b0, den_q});
  assign rem_d   = ge ? 8'(shifted - {1'b0, den_q}) : shifted[7:0];
  assign quo_d   = {quo_q[6:0], ge};

  assign done_o     = done_q;
  // the most negative quotient wraps on its own through the 8-bit negate
  assign quotient_o = neg_q ? (~quo_q + 8'd1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= a_mag;
      den_q <= b_mag;
      neg_q <= dividend_i[7] ^ divisor_i[7];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule

`default_nettype wire

/* sv/rsc_back.sv */
// rsc_back: executes tokens on the operand stack and produces results.
// Depends on rsc_pkg and rsc_div; the stack is a memory with top cached.
`default_nettype none

module rsc_back #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsc_pkg::tok_t tok_i,
  input  logic          tok_empty_i,
  output logic          tok_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output rsc_pkg::res_t res_o
);

  import rsc_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  // entries below the top live in memory; the top sits in tos_q
  logic [7:0]       mem [STACK_DEPTH];
  back_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
  logic [IDX_W-1:0] cnt_m2;
  logic             skip_q, skip_d;
  logic [7:0]       tos_q, tos_d, rd_q;
  tok_kind_e        op_q, op_d;
  logic             take, mem_we, div_start, div_done;
  logic [7:0]       div_q;
  logic [15:0]      product;
  logic             is_op;

  assign take    = (state_q == BK_IDLE) && !tok_empty_i && !res_full_i;
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign cnt_m2  = IDX_W'(cnt_q - CNT_W'(2));
  assign product = rd_q * tos_q;
  assign is_op   = (tok_i.kind == TK_ADD) || (tok_i.kind == TK_SUB) ||
                   (tok_i.kind == TK_MUL) || (tok_i.kind == TK_DIV);

  rsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take && !skip_q && is_op && cnt_q >= CNT_W'(2)) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_d = (op_q == TK_DIV && tos_q != 8'd0) ? BK_DIV : BK_IDLE;
      end
      BK_DIV: begin
        if (div_done) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    tok_pop_o        = 1'b0;
    res_push_o       = 1'b0;
    res_o.value      = '0;
    res_o.status     = ST_OK;
    cnt_d            = cnt_q;
    skip_d           = skip_q;
    tos_d            = tos_q;
    op_d             = op_q;
    mem_we           = 1'b0;
    div_start        = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          tok_pop_o = 1'b1;
          op_d      = tok_i.kind;
          if (skip_q) begin
            if (tok_i.kind == TK_NL) begin
              skip_d = 1'b0;
            end
          end else begin
            unique case (tok_i.kind)
              TK_DIGIT: begin
                if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
                  res_push_o   = 1'b1;
                  res_o.status = ST_OVERFLOW;
                  cnt_d        = '0;
                  skip_d       = 1'b1;
                end else begin
                  mem_we = (cnt_q != '0);
                  tos_d  = {4'd0, tok_i.digit};
                  cnt_d  = cnt_q + CNT_W'(1);
                end
              end
              TK_ADD, TK_SUB, TK_MUL, TK_DIV: begin
                if (cnt_q < CNT_W'(2)) begin
                  res_push_o   = 1'b1;
                  res_o.status = ST_UNDERFLOW;
                  cnt_d        = '0;
                  skip_d       = 1'b1;
                end
              end
              TK_EQ, TK_NL: begin
                res_push_o = 1'b1;
                cnt_d      = '0;
                skip_d     = (tok_i.kind == TK_EQ);
                if (cnt_q == '0) begin
                  res_o.status = ST_UNDERFLOW;
                end else if (cnt_q > CNT_W'(1)) begin
                  res_o.status = ST_EXTRA;
                end else begin
                  res_o.value = tos_q;
                end
              end
              TK_BAD: begin
                res_push_o   = 1'b1;
                res_o.status = ST_BAD_CHAR;
                cnt_d        = '0;
                skip_d       = 1'b1;
              end
            endcase
          end
        end
      end
      BK_EXEC: begin
        unique case (op_q)
          TK_ADD: begin
            tos_d = rd_q + tos_q;
            cnt_d = cnt_m1;
          end
          TK_SUB: begin
            tos_d = rd_q - tos_q;
            cnt_d = cnt_m1;
          end
          TK_MUL: begin
            tos_d = product[7:0];
            cnt_d = cnt_m1;
          end
          TK_DIV: begin
            if (tos_q == 8'd0) begin
              res_push_o   = 1'b1;
              res_o.status = ST_DIV_ZERO;
              cnt_d        = '0;
              skip_d       = 1'b1;
            end else begin
              div_start = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      BK_DIV: begin
        if (div_done) begin
          tos_d = div_q;
          cnt_d = cnt_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    op_q  <= op_d;
  end

  // spill the old top on push; read the entry under the top every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_m1[IDX_W-1:0]] <= tos_q;
    end
    rd_q <= mem[cnt_m2];
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_res_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (cnt_q == '0))
    else $error("stack not emptied after a result");

  a_div_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (!skip_q && cnt_q >= CNT_W'(2)))
    else $error("division running with bad stack context");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == BK_DIV))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

/* sv/rpn_stack_calculator.sv */
// rpn_stack_calculator: top level of the postfix expression evaluator.
// Depends on rsc_pkg, rsc_front, rsc_fifo and rsc_back.
//
//   channel   handshake        payload
//   input     push / full      ch_i[7:0]
//   result    pop / empty      value_o[7:0] (signed), status_o[2:0]
//
// The back end runs a digit in BK_IDLE, + - * also in BK_EXEC, / also BK_DIV
// (iterative divider, one quotient bit per cycle); spaces never reach it.
// The front takes one character a cycle while the two-entry token queue
// has room; the back end stalls on a full result queue or outside BK_IDLE.
// Reset clears the stack count and the skip flag at once; no clearing pass.
`default_nettype none

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic [7:0]        ch_i,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic signed [7:0] value_o,
  output logic [2:0]        status_o
);

  import rsc_pkg::*;

  tok_t tok_in, tok_out;
  logic tok_push, tok_full, tok_pop, tok_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  rsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .ch_i       (ch_i),
    .full_o     (full),
    .tok_full_i (tok_full),
    .tok_push_o (tok_push),
    .tok_o      (tok_in)
  );

  rsc_fifo #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (TOK_Q_DEPTH)
  ) u_tok_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .data_o  (tok_out),
    .empty_o (tok_empty)
  );

  rsc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .tok_empty_i (tok_empty),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  rsc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign value_o  = res_out.value;
  assign status_o = res_out.status;

endmodule

`default_nettype wire
